### sv/stbs_pkg.sv
// Shared types and codes for the sorted-table binary search block.
package stbs_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam int KEY_W = 16;
    localparam int PAY_W = 32;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } in_t;

    typedef struct packed {
        logic             op_echo;
        logic             found;
        logic [POS_W-1:0] match_position;
        logic [PAY_W-1:0] match_payload;
    } out_t;

    // One stored record as it sits in the table memory.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic probe;
        logic emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic op_search;
        logic empty;
        logic hit;
        logic range_done;
        logic out_free;
    } sts_t;

endpackage

### sv/stbs_ram.sv
// Generic single-port RAM with registered read data.
module stbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/stbs_ctrl.sv
// Sequencer for request intake, search probes and result hand-off.
module stbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output stbs_pkg::cmd_t cmd,
    input  stbs_pkg::sts_t sts
);
    import stbs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.load_item = accept;
        cmd.probe     = (state_reg == ST_PROBE);
        cmd.emit      = (state_reg == ST_FINISH) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Writes and searches of an empty table finish at once.
                    if (sts.op_search && !sts.empty)
                    begin
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PROBE:
            begin
                if (sts.hit || sts.range_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while previous one still in flight");
`endif

endmodule

### sv/stbs_dp.sv
// Search datapath: bounds, probe address, compare, result and output registers.
module stbs_dp #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [stbs_pkg::CNT_W-1:0]  cfg_wr_data,
    input  stbs_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output stbs_pkg::out_t              out_data,
    input  stbs_pkg::cmd_t              cmd,
    output stbs_pkg::sts_t              sts
);
    import stbs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CNT_W-1:0] entries_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [AW:0]      lo_reg;
    logic [AW:0]      lo_next;
    logic [AW:0]      hi_reg;
    logic [AW:0]      hi_next;
    logic [AW-1:0]    mid_reg;
    logic [AW-1:0]    mid_next;
    out_t             res_reg;
    out_t             res_next;
    out_t             out_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [AW+5:0]    n_wide;
    logic [AW:0]      hi_start;
    logic [AW+1:0]    sum_start;
    logic [AW-1:0]    mid_start;
    logic [AW+3:0]    pos_wide;
    logic             pos_ok;
    logic [AW+3:0]    mid_wide;

    rec_t             rd_rec;
    logic [$bits(rec_t)-1:0] rd_bits;
    logic             hit;
    logic             less;
    logic [AW:0]      lo_probe;
    logic [AW:0]      hi_probe;
    logic [AW+1:0]    sum_probe;
    logic [AW-1:0]    mid_probe;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    rec_t             ram_wrec;

    // Clamp the entry count to the table depth.
    assign n_wide    = (AW+6)'(entries_reg);
    assign hi_start  = (n_wide > (AW+6)'(DEPTH)) ? (AW+1)'(DEPTH) : n_wide[AW:0];
    assign sum_start = (AW+2)'(hi_start) - (AW+2)'(1);
    assign mid_start = sum_start[AW:1];

    assign pos_wide = (AW+4)'(in_data.position);
    assign pos_ok   = pos_wide < (AW+4)'(DEPTH);

    // Compare against the record read for the current midpoint.
    assign rd_rec    = rec_t'(rd_bits);
    assign hit       = (key_reg == rd_rec.key);
    assign less      = (key_reg < rd_rec.key);
    assign lo_probe  = less ? lo_reg : ((AW+1)'(mid_reg) + (AW+1)'(1));
    assign hi_probe  = less ? (AW+1)'(mid_reg) : hi_reg;
    assign sum_probe = (AW+2)'(lo_probe) + (AW+2)'(hi_probe) - (AW+2)'(1);
    assign mid_probe = sum_probe[AW:1];
    assign mid_wide  = (AW+4)'(mid_reg);

    always_comb
    begin
        sts.op_search  = (in_data.op == OP_SEARCH);
        sts.empty      = (hi_start == '0);
        sts.hit        = hit;
        sts.range_done = (lo_probe >= hi_probe);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // The next midpoint goes straight to the RAM so one probe fits in each cycle.
    always_comb
    begin
        ram_we           = cmd.load_item && (in_data.op == OP_WRITE) && pos_ok;
        ram_wrec.key     = in_data.key;
        ram_wrec.payload = in_data.payload;
        if (cmd.load_item)
        begin
            ram_addr = (in_data.op == OP_WRITE) ? pos_wide[AW-1:0] : mid_start;
        end
        else
        begin
            ram_addr = mid_probe;
        end
    end

    stbs_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wrec),
        .rdata (rd_bits)
    );

    always_comb
    begin
        key_next = key_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        res_next = res_reg;
        if (cmd.load_item)
        begin
            key_next                = in_data.key;
            lo_next                 = '0;
            hi_next                 = hi_start;
            mid_next                = mid_start;
            res_next.op_echo        = in_data.op;
            res_next.found          = 1'b0;
            res_next.match_position = '0;
            res_next.match_payload  = '0;
        end
        else if (cmd.probe)
        begin
            if (hit)
            begin
                res_next.found          = 1'b1;
                res_next.match_position = mid_wide[POS_W-1:0];
                res_next.match_payload  = rd_rec.payload;
            end
            else
            begin
                lo_next  = lo_probe;
                hi_next  = hi_probe;
                mid_next = mid_probe;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |-> ((AW+1)'(mid_reg) >= lo_reg) && ((AW+1)'(mid_reg) < hi_reg))
        else $error("probe midpoint outside open range");
    a_hi_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |-> (hi_reg <= (AW+1)'(DEPTH)))
        else $error("search bound beyond table depth");
    a_write_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (res_reg.op_echo == OP_WRITE)) |=> !out_data.found)
        else $error("write request reported a match");
`endif

endmodule

### sv/sorted_table_binary_search.sv
// Sorted-table binary search: top level tying the sequencer to the datapath.
//
// Holds a table of DEPTH records (16-bit key, 32-bit payload) in one RAM with
// registered read. A write request stores its record at position (positions
// of DEPTH or more are dropped) and answers with found, position and payload
// all zero. A search request bisects positions 0 .. entries_in_use-1 (count
// clamped to DEPTH); keys must be stored in ascending order. Each probe is
// one RAM read. A request is taken, the search runs up to ceil(log2(n+1))
// probes for n entries searched, and the result then moves into the output
// register once that is free; a write or a search of an empty table skips
// the probes. One request is in work at a time; the next may be taken while
// the previous result waits in the output register. The table needs no
// clearing after reset; entries must be written before they are searched.
// entries_in_use must be written through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block itself does not enforce this.
module sorted_table_binary_search #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [stbs_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  stbs_pkg::in_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output stbs_pkg::out_t             out_data
);
    import stbs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    stbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    stbs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

### bench/sorted_table_binary_search_tb.sv
// Self-checking testbench for the sorted-table binary search block.
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH     = 16;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int QUIET_TAIL      = 300;

    typedef enum int
    {
        FILL_SPREAD,
        FILL_DENSE,
        FILL_SCRAMBLED
    } fill_mode_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    in_t              in_data     = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    out_t             out_data;

    // Shadow copy of the table and of the search count
    logic [KEY_W-1:0] table_key [TABLE_DEPTH];
    logic [PAY_W-1:0] table_payload [TABLE_DEPTH];
    int               search_count = 0;

    out_t pending_results[$];
    out_t oldest_result;
    bit   quiet  = 1'b0;
    int   errors = 0;

    sorted_table_binary_search #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("sorted_table_binary_search verification failed");
        $finish;
    end

    // Update the shadow table for a write, or bisect it for a search.
    function automatic out_t apply_request(in_t req);
        out_t res;
        int   lo;
        int   hi;
        int   mid;
        bit   hit;
        res = '0;
        res.op_echo = req.op;
        if (req.op == OP_WRITE)
        begin
            table_key[req.position]     = req.key;
            table_payload[req.position] = req.payload;
        end
        else
        begin
            lo  = 0;
            hi  = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
            hit = 1'b0;
            while (!hit && lo < hi)
            begin
                mid = (lo + hi - 1) / 2;
                if (req.key == table_key[mid])
                begin
                    res.found          = 1'b1;
                    res.match_position = POS_W'(mid);
                    res.match_payload  = table_payload[mid];
                    hit                = 1'b1;
                end
                else if (req.key < table_key[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
        end
        return res;
    endfunction

    function automatic in_t make_request(logic op, logic [POS_W-1:0] pos,
                                         logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        in_t req;
        req.op       = op;
        req.position = pos;
        req.key      = key;
        req.payload  = pay;
        return req;
    endfunction

    // Called at a rising edge; returns at the edge the request is taken.
    task automatic send_request(in_t req);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_request(req));
    endtask

    task automatic search_for(logic [KEY_W-1:0] key);
        send_request(make_request(OP_SEARCH, POS_W'($urandom_range(0, 15)), key, $urandom));
    endtask

    // Hold off until every result is back and the block has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        search_count = int'(value);
    endtask

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: %h", out_data);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_data.op_echo !== oldest_result.op_echo)
                begin
                    $error("op_echo: expected %h, got %h",
                           oldest_result.op_echo, out_data.op_echo);
                    errors++;
                end
                if (out_data.found !== oldest_result.found)
                begin
                    $error("found: expected %h, got %h",
                           oldest_result.found, out_data.found);
                    errors++;
                end
                if (out_data.match_position !== oldest_result.match_position)
                begin
                    $error("match_position: expected %h, got %h",
                           oldest_result.match_position, out_data.match_position);
                    errors++;
                end
                if (out_data.match_payload !== oldest_result.match_payload)
                begin
                    $error("match_payload: expected %h, got %h",
                           oldest_result.match_payload, out_data.match_payload);
                    errors++;
                end
            end
        end
    end

    // Count is zero out of reset, so nothing in the table is read.
    task automatic test_empty_table();
        search_for(16'h0000);
        search_for(16'hFFFF);
    endtask

    task automatic test_table_fill();
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            key = KEY_W'(i * 4096 + $urandom_range(0, 4095));
            pay = $urandom;
            if (i == 0)
            begin
                key = 16'h0000;
                pay = 32'h0000_0000;
            end
            if (i == TABLE_DEPTH - 1)
            begin
                key = 16'hFFFF;
                pay = 32'hFFFF_FFFF;
            end
            send_request(make_request(OP_WRITE, POS_W'(i), key, pay));
        end
    endtask

    task automatic test_search_edges();
        wait_idle();
        write_count(5'd16);
        search_for(16'h0000);
        search_for(16'hFFFF);
        search_for(table_key[7]);
        search_for(table_key[3] + 16'd1);
        wait_idle();
        write_count(5'd1);
        search_for(table_key[0]);
        search_for(table_key[15]);
        // Counts above the depth clamp to a full table
        wait_idle();
        write_count(5'd31);
        search_for(16'hFFFF);
    endtask

    // Break the order at the first probe and follow the bisection blindly.
    task automatic test_unsorted_keys();
        send_request(make_request(OP_WRITE, 4'd7, 16'h0001, $urandom));
        search_for(16'h0001);
        search_for(table_key[8]);
        search_for(table_key[3]);
    endtask

    task automatic test_random_traffic();
        int               sent;
        int               span;
        int               pick;
        int               idx;
        fill_mode_t       mode;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       write_count(5'd0);
                1:       write_count(5'd1);
                2:       write_count(5'd16);
                3:       write_count(5'd31);
                default: write_count(CNT_W'($urandom_range(0, 31)));
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                pick = $urandom_range(0, 99);
                mode = (pick < 50) ? FILL_SPREAD : (pick < 85) ? FILL_DENSE : FILL_SCRAMBLED;
                key  = KEY_W'($urandom_range(0, 65000));
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    case (mode)
                        FILL_SPREAD: key = KEY_W'(i * 4096 + $urandom_range(0, 4095));
                        FILL_DENSE:  key = (i == 0) ? key : key + KEY_W'($urandom_range(0, 2));
                        default:     key = KEY_W'($urandom);
                    endcase
                    send_request(make_request(OP_WRITE, POS_W'(i), key, $urandom));
                    sent++;
                end
            end
            repeat ($urandom_range(20, 80))
            begin
                span = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
                pick = $urandom_range(0, 99);
                if (pick >= 80)
                begin
                    // Mostly rewrite the payload under the same key to keep order
                    pos = POS_W'($urandom_range(0, 15));
                    key = ($urandom_range(0, 9) < 7) ? table_key[pos] : KEY_W'($urandom);
                    send_request(make_request(OP_WRITE, pos, key, $urandom));
                end
                else if (span == 0 || pick >= 60)
                    search_for(KEY_W'($urandom));
                else
                begin
                    idx = $urandom_range(0, span - 1);
                    if (pick < 45)
                        search_for(table_key[idx]);
                    else if (pick < 52)
                        search_for(table_key[idx] + 16'd1);
                    else
                        search_for(table_key[idx] - 16'd1);
                end
                sent++;
                quiet = (sent >= RANDOM_REQUESTS - QUIET_TAIL);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_table_fill();
        test_search_edges();
        test_unsorted_keys();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("sorted_table_binary_search verification clean");
        else
            $display("sorted_table_binary_search verification failed");
        $finish;
    end

endmodule

### files.f
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/stbs_ctrl.sv
sv/stbs_dp.sv
sv/sorted_table_binary_search.sv
bench/sorted_table_binary_search_tb.sv
